// File: hdl/ogifs_pkg.sv
// types and constants shared by the occupancy grid inflate and free search block
package ogifs_pkg;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS      = 2'd2;
    localparam logic [1:0] REG_THRESHOLD   = 2'd3;

    localparam int CFG_DATA_W = 9;
    localparam logic signed [7:0] OCC_UNKNOWN = -8'sd1;
    localparam int RESET_GRID = 256;
    localparam int RESET_RADIUS = 10;
    localparam logic [6:0] RESET_THRESHOLD = 7'd70;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [7:0]        cell_x;
        logic [7:0]        cell_y;
        logic signed [7:0] occupancy;
    } t_in_word;

    typedef struct packed {
        logic       blocked;
        logic [7:0] free_x;
        logic [7:0] free_y;
        logic       found;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_CTR_START,
        S_CTR_SCAN,
        S_CAND,
        S_CAND_SCAN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic write;
        logic ring_init;
        logic ring_next;
        logic win_start;
        logic res_load;
        logic res_blocked;
        logic res_center;
        logic res_found;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       in_grid;
        logic       cand_ok;
        logic       ring_end;
        logic       win_done;
        logic       win_blk;
        logic       out_busy;
    } t_dp_sts;

endpackage

// File: hdl/ogifs_ifs.sv
// valid/ready channel interfaces for items, results and configuration
interface ogifs_in_if import ogifs_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word word;
    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

interface ogifs_out_if import ogifs_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word word;
    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

interface ogifs_cfg_if import ogifs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/ogifs_ctrl.sv
// sequencing state machine for writes, blocked queries and ring search
module ogifs_ctrl import ogifs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    input  logic [1:0] i_in_cmd,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_cmd)
                        CMD_WRITE:  n_state = S_WRITE;
                        CMD_QUERY:  n_state = S_CTR_START;
                        CMD_SEARCH: n_state = S_CTR_START;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_WRITE: n_state = S_IDLE;
            S_CTR_START: begin
                if (!i_sts.in_grid) begin
                    n_state = (i_sts.cmd == CMD_QUERY) ? S_OUT : S_CAND;
                end else begin
                    n_state = S_CTR_SCAN;
                end
            end
            S_CTR_SCAN: begin
                if (i_sts.win_done) begin
                    if (i_sts.cmd == CMD_QUERY || !i_sts.win_blk) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_CAND;
                    end
                end
            end
            S_CAND: begin
                if (i_sts.ring_end) begin
                    n_state = S_OUT;
                end else if (i_sts.cand_ok) begin
                    n_state = S_CAND_SCAN;
                end
            end
            S_CAND_SCAN: begin
                if (i_sts.win_done) begin
                    n_state = i_sts.win_blk ? S_CAND : S_OUT;
                end
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_WRITE: o_cmd.write = 1'b1;
            S_CTR_START: begin
                if (!i_sts.in_grid) begin
                    if (i_sts.cmd == CMD_QUERY) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_blocked = 1'b1;
                        o_cmd.res_found = 1'b1;
                    end else begin
                        o_cmd.ring_init = 1'b1;
                    end
                end else begin
                    o_cmd.win_start = 1'b1;
                end
            end
            S_CTR_SCAN: begin
                if (i_sts.win_done) begin
                    if (i_sts.cmd == CMD_QUERY) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_blocked = i_sts.win_blk;
                        o_cmd.res_found = 1'b1;
                    end else if (!i_sts.win_blk) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_center = 1'b1;
                        o_cmd.res_found = 1'b1;
                    end else begin
                        o_cmd.ring_init = 1'b1;
                    end
                end
            end
            S_CAND: begin
                if (i_sts.ring_end) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_blocked = 1'b1;
                end else if (i_sts.cand_ok) begin
                    o_cmd.win_start = 1'b1;
                end else begin
                    o_cmd.ring_next = 1'b1;
                end
            end
            S_CAND_SCAN: begin
                if (i_sts.win_done) begin
                    if (i_sts.win_blk) begin
                        o_cmd.ring_next = 1'b1;
                    end else begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_blocked = 1'b1;
                        o_cmd.res_center = 1'b1;
                        o_cmd.res_found = 1'b1;
                    end
                end
            end
            S_OUT: o_cmd.push = !i_sts.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: hdl/ogifs_dp.sv
// grid store, window scanner, ring walker, settings and result registers
module ogifs_dp import ogifs_pkg::*; #(
    parameter int GRID_DIM   = 256,
    parameter int RADIUS_MAX = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_word              i_in_word,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    input  logic                  i_out_ready,
    output t_dp_sts               o_sts,
    output logic                  o_out_valid,
    output t_out_word             o_out_word
);

    localparam int CW   = $clog2(GRID_DIM);
    localparam int GW_W = $clog2(GRID_DIM + 1);
    localparam int RW   = $clog2(RADIUS_MAX + 1);
    localparam int MW   = (GW_W > 8) ? GW_W : 8;
    localparam int SW   = MW + 3;
    localparam int BW   = ((CW > RW) ? CW : RW) + 1;
    localparam int AW   = 2 * CW;
    localparam int DEPTH = GRID_DIM * GRID_DIM;
    localparam int GRID_RST = (GRID_DIM < RESET_GRID) ? GRID_DIM : RESET_GRID;
    localparam int RAD_RST  = (RADIUS_MAX < RESET_RADIUS) ? RADIUS_MAX : RESET_RADIUS;

    function automatic logic [GW_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        int t;
        t = int'(v);
        if (t < 1) t = 1;
        if (t > GRID_DIM) t = GRID_DIM;
        return GW_W'(t);
    endfunction

    function automatic logic [RW-1:0] clamp_rad(input logic [3:0] v);
        int t;
        t = int'(v);
        if (t > RADIUS_MAX) t = RADIUS_MAX;
        return RW'(t);
    endfunction

    logic [GW_W-1:0] r_gw, r_gh;
    logic [RW-1:0]   r_rad;
    logic [6:0]      r_thr;

    logic [1:0]        r_cmd;
    logic [7:0]        r_x, r_y;
    logic signed [7:0] r_occ;

    logic signed [SW-1:0] r_s, r_i, r_j;
    logic signed [SW-1:0] n_s, n_i, n_j;
    logic signed [SW-1:0] w_cx, w_cy, w_gw_s, w_gh_s, w_step, w_jn;
    logic [MW-1:0]        w_smax;

    logic          r_mem [DEPTH];
    logic          r_rd;
    logic [CW-1:0] r_wx, r_wy, r_x0, r_x1, r_y1;
    logic          r_issuing, r_pend;
    logic [CW-1:0] w_x0, w_x1, w_y0, w_y1;
    logic [BW-1:0] w_cxb, w_cyb, w_radb, w_gwm1, w_ghm1, w_xhi, w_yhi;
    logic          w_wr_ok, w_occupied, w_hit;

    logic       r_res_blk, r_res_found;
    logic [7:0] r_res_x, r_res_y;
    logic       r_ov;
    t_out_word  r_ow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw  <= GW_W'(GRID_RST);
            r_gh  <= GW_W'(GRID_RST);
            r_rad <= RW'(RAD_RST);
            r_thr <= RESET_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GRID_WIDTH:  r_gw  <= clamp_dim(i_cfg_data);
                REG_GRID_HEIGHT: r_gh  <= clamp_dim(i_cfg_data);
                REG_RADIUS:      r_rad <= clamp_rad(i_cfg_data[3:0]);
                REG_THRESHOLD:   r_thr <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_in_word.cmd;
            r_x   <= i_in_word.cell_x;
            r_y   <= i_in_word.cell_y;
            r_occ <= i_in_word.occupancy;
        end
    end

    // ring walk around the item cell
    always_comb begin
        w_cx   = $signed(SW'(r_x)) + r_i;
        w_cy   = $signed(SW'(r_y)) + r_j;
        w_gw_s = $signed(SW'(r_gw));
        w_gh_s = $signed(SW'(r_gh));
        w_smax = MW'(r_x);
        if (MW'(r_y) > w_smax) w_smax = MW'(r_y);
        if (MW'(r_gw) > w_smax) w_smax = MW'(r_gw);
        if (MW'(r_gh) > w_smax) w_smax = MW'(r_gh);
        w_step = (r_i == -r_s || r_i == r_s) ? SW'(1) : (r_s <<< 1);
        w_jn = r_j + w_step;
        n_s = r_s;
        n_i = r_i;
        n_j = w_jn;
        if (w_jn > r_s) begin
            if (r_i == r_s) begin
                n_s = r_s + SW'(1);
                n_i = -(r_s + SW'(1));
                n_j = -(r_s + SW'(1));
            end else begin
                n_i = r_i + SW'(1);
                n_j = -r_s;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s <= '0;
            r_i <= '0;
            r_j <= '0;
        end else if (i_cmd.ring_init) begin
            r_s <= SW'(1);
            r_i <= -SW'(1);
            r_j <= -SW'(1);
        end else if (i_cmd.ring_next) begin
            r_s <= n_s;
            r_i <= n_i;
            r_j <= n_j;
        end
    end

    // clipped inflation window around the current center
    always_comb begin
        w_cxb  = BW'(w_cx[CW-1:0]);
        w_cyb  = BW'(w_cy[CW-1:0]);
        w_radb = BW'(r_rad);
        w_gwm1 = BW'(r_gw - GW_W'(1));
        w_ghm1 = BW'(r_gh - GW_W'(1));
        w_xhi  = w_cxb + w_radb;
        w_yhi  = w_cyb + w_radb;
        w_x0 = (w_cxb >= w_radb) ? CW'(w_cxb - w_radb) : '0;
        w_y0 = (w_cyb >= w_radb) ? CW'(w_cyb - w_radb) : '0;
        w_x1 = (w_xhi > w_gwm1) ? CW'(w_gwm1) : CW'(w_xhi);
        w_y1 = (w_yhi > w_ghm1) ? CW'(w_ghm1) : CW'(w_yhi);
    end

    assign w_hit = r_pend && r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing <= 1'b0;
            r_pend    <= 1'b0;
        end else if (i_cmd.win_start) begin
            r_issuing <= 1'b1;
            r_pend    <= 1'b0;
        end else if (w_hit) begin
            r_issuing <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_pend <= r_issuing;
            if (r_issuing && r_wx == r_x1 && r_wy == r_y1) begin
                r_issuing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.win_start) begin
            r_wx <= w_x0;
            r_wy <= w_y0;
            r_x0 <= w_x0;
            r_x1 <= w_x1;
            r_y1 <= w_y1;
        end else if (r_issuing) begin
            if (r_wx == r_x1) begin
                r_wx <= r_x0;
                r_wy <= r_wy + CW'(1);
            end else begin
                r_wx <= r_wx + CW'(1);
            end
        end
    end

    assign w_wr_ok = (32'(r_x) < GRID_DIM) && (32'(r_y) < GRID_DIM);
    assign w_occupied = (r_occ != OCC_UNKNOWN) && (r_occ > $signed({1'b0, r_thr}));

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && w_wr_ok) begin
            r_mem[AW'({CW'(r_y), CW'(r_x)})] <= w_occupied;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[{r_wy, r_wx}];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_blk   <= i_cmd.res_blocked;
            r_res_found <= i_cmd.res_found;
            r_res_x     <= i_cmd.res_center ? w_cx[7:0] : 8'd0;
            r_res_y     <= i_cmd.res_center ? w_cy[7:0] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.push) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_ow.blocked <= r_res_blk;
            r_ow.free_x  <= r_res_x;
            r_ow.free_y  <= r_res_y;
            r_ow.found   <= r_res_found;
        end
    end

    always_comb begin
        o_sts.cmd      = r_cmd;
        o_sts.in_grid  = (w_cx >= 0) && (w_cx < w_gw_s) && (w_cy >= 0) && (w_cy < w_gh_s);
        o_sts.cand_ok  = (w_cx > 0) && (w_cx < w_gw_s) && (w_cy > 0) && (w_cy < w_gh_s);
        o_sts.ring_end = r_s > $signed(SW'(w_smax));
        o_sts.win_done = w_hit || (!r_issuing && !r_pend);
        o_sts.win_blk  = w_hit;
        o_sts.out_busy = r_ov && !i_out_ready;
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_ow;

endmodule

// File: hdl/occupancy_grid_inflate_and_free_search_top.sv
// A query whose cell lies outside the grid reports it blocked without reading the grid
// store; otherwise it reads one cell per cycle through the single read port of the grid
// store from the inflation window clipped to the grid, up to (2*RADIUS_MAX+1)^2 cells, and
// stops at the first occupied cell. A search first does the same check on its own cell,
// then walks the rings around it one position a cycle between window checks and runs one
// such window check for every position inside the grid off row 0 and column 0, so its time
// grows with the distance to the nearest free cell. One result word may wait in the output
// register while the next item is taken. The grid store has no reset: cells read before
// they are written hold unknown values.
module occupancy_grid_inflate_and_free_search_top import ogifs_pkg::*; #(
    parameter int GRID_DIM   = 256,
    parameter int RADIUS_MAX = 15
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ogifs_in_if.sink     i_in,
    ogifs_out_if.source  o_out,
    ogifs_cfg_if.sink    i_cfg
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign i_cfg.ready = 1'b1;

    ogifs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .i_in_cmd   (i_in.word.cmd),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd)
    );

    ogifs_dp #(
        .GRID_DIM   (GRID_DIM),
        .RADIUS_MAX (RADIUS_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in.word),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_cmd       (w_cmd),
        .i_out_ready (o_out.ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out.valid),
        .o_out_word  (o_out.word)
    );

    a_idle_no_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> w_sts.win_done)
        else $error("input taken while a window scan is running");

    a_not_found_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.word.found) |-> o_out.word.blocked)
        else $error("search gave up on a free start cell");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.word.found) |->
            (o_out.word.free_x == 8'd0 && o_out.word.free_y == 8'd0))
        else $error("not-found word carries coordinates");

    a_word_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_cmd.push))
        else $error("result word appeared without a push");

endmodule

// File: tb/tb.sv
// testbench for the occupancy grid inflation and free cell search block
module tb;
    import ogifs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int DIM = 256;
    localparam int IDLE_LIMIT = 2000000;
    localparam int ITEMS_PER_PHASE = 120;

    typedef struct {
        bit         is_cfg;
        logic [1:0] code;
        logic [7:0] x;
        logic [7:0] y;
        logic [8:0] val;
        bit         typed;
        t_out_word  res;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ogifs_in_if  in_ch ();
    ogifs_out_if out_ch ();
    ogifs_cfg_if cfg_ch ();

    occupancy_grid_inflate_and_free_search_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    bit         occ_map [DIM*DIM];
    int         gw = RESET_GRID;
    int         gh = RESET_GRID;
    int         rad = RESET_RADIUS;
    logic [6:0] thr = RESET_THRESHOLD;

    t_out_word  pending_results[$];
    int         errors = 0;
    int         n_items = 0;
    int         n_results = 0;
    int         n_notfound = 0;
    int         n_cfg = 0;
    int         in_idle_pct = 0;
    int         out_stall_pct = 0;
    int         hold_cycles = 0;
    int         idle_cycles = 0;

    t_stim_row directed[$] = '{
        '{1, REG_GRID_WIDTH,  0, 0, 9'd8,   0, '0},
        '{1, REG_GRID_HEIGHT, 0, 0, 9'd8,   0, '0},
        '{1, REG_RADIUS,      0, 0, 9'd1,   0, '0},
        '{1, REG_THRESHOLD,   0, 0, 9'd70,  0, '0},
        '{0, CMD_QUERY,   3,   3, 9'd0,   1, '{1'b0, 8'd0, 8'd0, 1'b1}},
        '{0, CMD_QUERY, 200,   9, 9'd0,   1, '{1'b1, 8'd0, 8'd0, 1'b1}},
        '{0, CMD_SEARCH,  2,   2, 9'd0,   1, '{1'b0, 8'd2, 8'd2, 1'b1}},
        '{0, CMD_WRITE,   4,   4, 9'd71,  0, '0},
        '{0, CMD_QUERY,   3,   3, 9'd0,   0, '0},
        '{0, CMD_QUERY,   0,   0, 9'd0,   0, '0},
        '{0, CMD_WRITE,   4,   4, 9'd70,  0, '0},
        '{0, CMD_QUERY,   5,   5, 9'd0,   1, '{1'b0, 8'd0, 8'd0, 1'b1}},
        '{0, CMD_WRITE,   1,   1, 9'd127, 0, '0},
        '{0, CMD_SEARCH,  1,   1, 9'd0,   0, '0},
        '{0, CMD_WRITE,   1,   1, 9'hFF,  0, '0},
        '{0, CMD_WRITE,   6,   6, 9'h80,  0, '0},
        '{0, CMD_UNUSED,  7,   7, 9'd0,   0, '0},
        '{0, CMD_WRITE,   7,   7, 9'd100, 0, '0},
        '{0, CMD_SEARCH,  7,   7, 9'd0,   0, '0},
        '{1, REG_THRESHOLD,   0, 0, 9'd0,   0, '0},
        '{0, CMD_WRITE,   2,   2, 9'd0,   0, '0},
        '{0, CMD_WRITE,   2,   3, 9'hFF,  0, '0},
        '{0, CMD_QUERY,   2,   2, 9'd0,   0, '0},
        '{1, REG_GRID_WIDTH,  0, 0, 9'd1,   0, '0},
        '{1, REG_GRID_HEIGHT, 0, 0, 9'd1,   0, '0},
        '{1, REG_RADIUS,      0, 0, 9'd0,   0, '0},
        '{0, CMD_SEARCH,  5,   5, 9'd0,   1, '{1'b1, 8'd0, 8'd0, 1'b0}},
        '{0, CMD_QUERY,   0,   0, 9'd0,   0, '0},
        '{0, CMD_SEARCH,  0,   0, 9'd0,   0, '0},
        '{1, REG_GRID_WIDTH,  0, 0, 9'd511, 0, '0},
        '{1, REG_GRID_HEIGHT, 0, 0, 9'd0,   0, '0},
        '{1, REG_RADIUS,      0, 0, 9'd15,  0, '0},
        '{1, REG_THRESHOLD,   0, 0, 9'd127, 0, '0},
        '{0, CMD_QUERY,  20,   0, 9'd0,   0, '0},
        '{0, CMD_SEARCH, 20,   0, 9'd0,   0, '0},
        '{1, REG_GRID_WIDTH,  0, 0, 9'd0,   0, '0},
        '{1, REG_GRID_HEIGHT, 0, 0, 9'd511, 0, '0},
        '{0, CMD_QUERY,   0,  20, 9'd0,   0, '0}
    };

    function automatic int clip(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic bit cell_blocked(int x, int y);
        if (x < 0 || y < 0 || x >= gw || y >= gh) return 1'b1;
        for (int yy = clip(y - rad, 0, gh - 1); yy <= clip(y + rad, 0, gh - 1); yy++)
            for (int xx = clip(x - rad, 0, gw - 1); xx <= clip(x + rad, 0, gw - 1); xx++)
                if (occ_map[yy*DIM + xx]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit free_candidate(int x, int y);
        return x > 0 && x < gw && y > 0 && y < gh && !cell_blocked(x, y);
    endfunction

    function automatic t_out_word predict_grid_answer(t_in_word w);
        t_out_word r;
        int x, y, smax, step;
        x = w.cell_x;
        y = w.cell_y;
        r = '{cell_blocked(x, y), 8'd0, 8'd0, 1'b1};
        if (w.cmd == CMD_QUERY) return r;
        if (!r.blocked) begin
            r.free_x = 8'(x);
            r.free_y = 8'(y);
            return r;
        end
        smax = x;
        if (y > smax) smax = y;
        if (gw > smax) smax = gw;
        if (gh > smax) smax = gh;
        for (int s = 1; s <= smax; s++) begin
            for (int i = -s; i <= s; i++) begin
                step = (i == -s || i == s) ? 1 : 2*s;
                for (int j = -s; j <= s; j += step) begin
                    if (free_candidate(x + i, y + j)) begin
                        r.free_x = 8'(x + i);
                        r.free_y = 8'(y + j);
                        return r;
                    end
                end
            end
        end
        r.found = 1'b0;
        return r;
    endfunction

    // state update on an accepted word
    task automatic grid_accept(t_in_word w, bit typed, t_out_word res);
        n_items++;
        if (w.cmd == CMD_WRITE)
            occ_map[w.cell_y*DIM + w.cell_x] =
                (w.occupancy != OCC_UNKNOWN) && (int'(w.occupancy) > int'(thr));
        else if (w.cmd != CMD_UNUSED)
            pending_results.insert(pending_results.size(),
                                   typed ? res : predict_grid_answer(w));
    endtask

    task automatic send_word(t_in_word w, bit typed = 0, t_out_word res = '0);
        if ($urandom_range(99) < in_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.word  <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        grid_accept(w, typed, res);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [8:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        n_cfg++;
        case (idx)
            REG_GRID_WIDTH:  gw  = clip(data, 1, DIM);
            REG_GRID_HEIGHT: gh  = clip(data, 1, DIM);
            REG_RADIUS:      rad = data[3:0];
            REG_THRESHOLD:   thr = data[6:0];
        endcase
    endtask

    // settings keep every window that a chosen item reads inside the preloaded area
    task automatic pick_setting();
        int k, w, h, r;
        k = $urandom_range(0, 9);
        if (k <= 6) begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
            r = ($urandom_range(0, 4) == 0) ? 15 : $urandom_range(0, 3);
        end else if (k == 7) begin
            w = $urandom_range(0, 511);
            h = $urandom_range(0, 1);
            r = $urandom_range(0, 2);
        end else if (k == 8) begin
            w = $urandom_range(0, 1);
            h = $urandom_range(0, 511);
            r = $urandom_range(0, 2);
        end else begin
            w = $urandom_range(0, 1) ? 1 : 12;
            h = $urandom_range(0, 1) ? 2 : 12;
            r = $urandom_range(0, 1) ? 0 : 15;
        end
        drain();
        cfg_write(REG_GRID_WIDTH, 9'(w));
        cfg_write(REG_GRID_HEIGHT, 9'(h));
        cfg_write(REG_RADIUS, 9'(r));
        cfg_write(REG_THRESHOLD, 9'($urandom_range(0, 127)));
    endtask

    function automatic logic signed [7:0] pick_occupancy();
        int r;
        r = $urandom_range(99);
        if (r < 2 && thr < 127) return 8'($urandom_range(thr + 1, 127));
        if (r < 10) return OCC_UNKNOWN;
        if (r < 20) return 8'($urandom_range(0, 126) - 128);
        return 8'($urandom_range(0, thr));
    endfunction

    function automatic t_in_word pick_word();
        t_in_word w;
        int r;
        bit search_ok;
        search_ok = gw <= 12 && gh <= 12;
        r = $urandom_range(99);
        w.occupancy = pick_occupancy();
        if ($urandom_range(99) < 85) begin
            w.cell_x = 8'($urandom_range(0, clip(gw, 1, 36) - 1));
            w.cell_y = 8'($urandom_range(0, clip(gh, 1, 36) - 1));
        end else if (r < 50) begin
            w.cell_x = 8'($urandom_range(0, 255));
            w.cell_y = 8'($urandom_range(0, 255));
            if (gh < DIM) w.cell_y = 8'($urandom_range(gh, 255));
            else w.cell_x = 8'($urandom_range(gw, 255));
        end else begin
            w.cell_x = 8'(clip(gw + $urandom_range(0, 3), 0, 255));
            w.cell_y = 8'(clip(gh + $urandom_range(0, 3), 0, 255));
        end
        if (r < 50) w.cmd = CMD_WRITE;
        else if (r < 70 || (r < 95 && !search_ok)) w.cmd = CMD_QUERY;
        else if (r < 95) w.cmd = CMD_SEARCH;
        else w.cmd = CMD_UNUSED;
        return w;
    endfunction

    task automatic check_answer(t_out_word got);
        t_out_word want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result word %p", $time, got);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        n_results++;
        if (!got.found) n_notfound++;
        if (got.blocked !== want.blocked) begin
            $display("%0t: blocked expected %0d actual %0d", $time, want.blocked, got.blocked);
            errors++;
        end
        if (got.free_x !== want.free_x) begin
            $display("%0t: free_x expected %0d actual %0d", $time, want.free_x, got.free_x);
            errors++;
        end
        if (got.free_y !== want.free_y) begin
            $display("%0t: free_y expected %0d actual %0d", $time, want.free_y, got.free_y);
            errors++;
        end
        if (got.found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
            errors++;
        end
    endtask

    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (out_ch.valid && out_ch.ready) check_answer(out_ch.word);
            if (hold_cycles > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        t_in_word w;
        in_ch.valid  <= 1'b0;
        in_ch.word   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_GRID_WIDTH;
        cfg_ch.data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // preload every cell that any chosen window can reach
        for (int y = 0; y < DIM; y++)
            for (int x = 0; x < DIM; x++)
                if ((x < 12 && y < 12) || (y == 0 && x < 40) || (x == 0 && y < 40))
                    send_word('{CMD_WRITE, x[7:0], y[7:0], 8'sd0});

        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                drain();
                cfg_write(directed[i].code, directed[i].val);
            end else begin
                w = '{directed[i].code, directed[i].x, directed[i].y, directed[i].val[7:0]};
                send_word(w, directed[i].typed, directed[i].res);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            in_idle_pct   = phase == 0 ? 8 : (phase == 1 ? 77 : 0);
            out_stall_pct = phase == 0 ? 77 : (phase == 1 ? 8 : 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 40 == 0) pick_setting();
                if (phase == 2 && n == 100) begin
                    hold_cycles = 2000;
                    for (int k = 0; k < 20; k++)
                        send_word('{CMD_QUERY,
                                   8'($urandom_range(0, clip(gw, 1, 36) - 1)),
                                   8'($urandom_range(0, clip(gh, 1, 36) - 1)), 8'sd0});
                end
                send_word(pick_word());
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("covered %0d words, %0d results (%0d not found), %0d register writes",
                 n_items, n_results, n_notfound, n_cfg);
        $display("across small, wide, tall and single cell grids with radius 0 to 15");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
hdl/ogifs_pkg.sv
hdl/ogifs_ifs.sv
hdl/ogifs_ctrl.sv
hdl/ogifs_dp.sv
hdl/occupancy_grid_inflate_and_free_search_top.sv
tb/tb.sv
